// File: rtl/core/frequency_ordered_list_assert.svh
// ----------------------------------------------------------------------------
// frequency_ordered_list_assert.svh
// Assertion macros used by the checker file of the ordered list block.
// ----------------------------------------------------------------------------
`ifndef FREQUENCY_ORDERED_LIST_ASSERT_SVH
`define FREQUENCY_ORDERED_LIST_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define FOL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: ante |-> cons");

// Next-cycle implication, sampled on clk, off while rst is high.
`define FOL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: ante |=> cons");

`endif

// File: rtl/core/fol_pkg.sv
// ----------------------------------------------------------------------------
// fol_pkg
// Shared constants and the controller-to-datapath command type.
// ----------------------------------------------------------------------------
`default_nettype none

package fol_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int COUNT_BITS_DEF = 16;

  localparam int KEY_BITS       = 6;
  localparam int SLOT_BITS      = 4;
  localparam int COUNT_OUT_BITS = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the key of a new transaction
    logic look;   // compare all cells, latch slot and incremented count
    logic move;   // shift the cells, register the result
  } fol_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/fol_ctrl.sv
// ----------------------------------------------------------------------------
// fol_ctrl
// Sequencer: load, look up, move, then strobe the result.
// ----------------------------------------------------------------------------
`default_nettype none

module fol_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output logic             done,
  output fol_pkg::fol_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MOVE
  } state_t;

  state_t state;

  assign busy     = (state != ST_IDLE);
  assign cmd.load = start && (state == ST_IDLE);
  assign cmd.look = (state == ST_LOOK);
  assign cmd.move = (state == ST_MOVE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) state <= ST_LOOK;
        end
        ST_LOOK: begin
          state <= ST_MOVE;
        end
        ST_MOVE: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fol_datapath.sv
// ----------------------------------------------------------------------------
// fol_datapath
// Row of key/count cells with parallel compare and a one-step shift.
// ----------------------------------------------------------------------------
`default_nettype none

module fol_datapath #(
  parameter int ENTRIES    = fol_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = fol_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fol_pkg::fol_cmd_t                    cmd,
  input  logic [fol_pkg::KEY_BITS-1:0]         key,
  output logic                                 hit,
  output logic [fol_pkg::SLOT_BITS-1:0]        old_slot,
  output logic [fol_pkg::SLOT_BITS-1:0]        new_slot,
  output logic [fol_pkg::COUNT_OUT_BITS-1:0]   new_count
);

  localparam int IDX_BITS = $clog2(ENTRIES);
  localparam int KB       = fol_pkg::KEY_BITS;
  localparam int SB       = fol_pkg::SLOT_BITS;
  localparam int OB       = fol_pkg::COUNT_OUT_BITS;

  logic [KB-1:0]         cell_key   [ENTRIES];
  logic [COUNT_BITS-1:0] cell_count [ENTRIES];

  logic [KB-1:0]         key_q;
  logic [IDX_BITS-1:0]   found_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic                  hit_q;

  logic [ENTRIES-1:0]    match;
  logic [IDX_BITS-1:0]   found;
  logic [COUNT_BITS-1:0] cur_count;
  logic [COUNT_BITS-1:0] inc_count;
  logic [ENTRIES-1:0]    stop;
  logic [IDX_BITS-1:0]   dest;

  // Lookup: first matching cell wins.
  always_comb begin
    found = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = (cell_key[i] == key_q);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) found = IDX_BITS'(i);
    end
  end

  assign cur_count = cell_count[found];
  assign inc_count = (cur_count == {COUNT_BITS{1'b1}}) ? cur_count
                                                        : COUNT_BITS'(cur_count + 1'b1);

  // Counts are non-increasing by slot, so the destination is the first cell
  // holding a smaller count, bounded by the entry's own slot.
  always_comb begin
    dest = found_q;
    for (int i = 0; i < ENTRIES; i++) begin
      stop[i] = (cell_count[i] < cnt_q) || (IDX_BITS'(i) == found_q);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (stop[i]) dest = IDX_BITS'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) key_q <= key;
    if (cmd.look) begin
      found_q <= found;
      cnt_q   <= inc_count;
      hit_q   <= |match;
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic [KB-1:0]         prev_key;
    logic [COUNT_BITS-1:0] prev_count;

    if (g == 0) begin : g_head
      assign prev_key   = key_q;
      assign prev_count = cnt_q;
    end else begin : g_body
      assign prev_key   = cell_key[g-1];
      assign prev_count = cell_count[g-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cell_key[g]   <= KB'(g + 1);
        cell_count[g] <= '0;
      end else if (cmd.move && hit_q) begin
        if (IDX_BITS'(g) == dest) begin
          cell_key[g]   <= key_q;
          cell_count[g] <= cnt_q;
        end else if ((IDX_BITS'(g) > dest) && (IDX_BITS'(g) <= found_q)) begin
          cell_key[g]   <= prev_key;
          cell_count[g] <= prev_count;
        end
      end
    end
  end

  logic [SB+IDX_BITS-1:0] old_ext;
  logic [SB+IDX_BITS-1:0] new_ext;
  logic [OB+COUNT_BITS-1:0] cnt_ext;

  assign old_ext = {{SB{1'b0}}, found_q};
  assign new_ext = {{SB{1'b0}}, dest};
  assign cnt_ext = {{OB{1'b0}}, cnt_q};

  // Result register; zeros on a miss.
  always_ff @(posedge clk) begin
    if (cmd.move) begin
      hit       <= hit_q;
      old_slot  <= hit_q ? old_ext[SB-1:0] : '0;
      new_slot  <= hit_q ? new_ext[SB-1:0] : '0;
      new_count <= hit_q ? cnt_ext[OB-1:0] : '0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/frequency_ordered_list.sv
// ----------------------------------------------------------------------------
// frequency_ordered_list
// Self-organizing table of keyed entries kept in order of access count.
// ----------------------------------------------------------------------------
//
//   channel  | handshake         | payload
//   ---------+-------------------+------------------------------------------
//   request  | start / busy      | key
//   result   | done (one cycle)  | hit, old_slot, new_slot, new_count
//
// A transaction runs as capture of the key, a lookup (parallel compare across
// all cells, count increment) and a move (destination search and single-step
// shift of the cell row). A new request is taken only while idle, at the
// earliest in the same cycle as the previous result strobe.
// Reset loads every cell at once (slot i holds key i+1, count zero); there is
// no clearing pass. The receiver cannot stall: done is high for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module frequency_ordered_list #(
  parameter int ENTRIES    = fol_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = fol_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [fol_pkg::KEY_BITS-1:0]        key,
  output logic                                done,
  output logic                                hit,
  output logic [fol_pkg::SLOT_BITS-1:0]       old_slot,
  output logic [fol_pkg::SLOT_BITS-1:0]       new_slot,
  output logic [fol_pkg::COUNT_OUT_BITS-1:0]  new_count
);

  // Commands from the sequencer to the cell row.
  fol_pkg::fol_cmd_t cmd;

  // Sequencer: hold busy from accept until the result strobe.
  fol_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // Cell row: compare, increment, advance the hit entry, register the result.
  fol_datapath #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .key       (key),
    .hit       (hit),
    .old_slot  (old_slot),
    .new_slot  (new_slot),
    .new_count (new_count)
  );

endmodule

`default_nettype wire

// File: rtl/core/fol_checker.sv
// ----------------------------------------------------------------------------
// fol_checker
// Port-level checks on request/result timing and result contents.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frequency_ordered_list_assert.svh"

module fol_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic                                done,
  input logic                                hit,
  input logic [fol_pkg::SLOT_BITS-1:0]       old_slot,
  input logic [fol_pkg::SLOT_BITS-1:0]       new_slot,
  input logic [fol_pkg::COUNT_OUT_BITS-1:0]  new_count
);

  logic accept;
  assign accept = start && !busy;

  `FOL_ASSERT_NXT(a_accept_busy, accept, busy && !done)
  `FOL_ASSERT_IMP(a_result_latency, accept, ##3 done)
  `FOL_ASSERT_IMP(a_done_idle, done, !busy)
  `FOL_ASSERT_IMP(a_miss_zero, done && !hit, old_slot == '0 && new_slot == '0 && new_count == '0)
  `FOL_ASSERT_IMP(a_move_forward, done && hit, new_slot <= old_slot && new_count != '0)

endmodule

bind frequency_ordered_list fol_checker u_fol_checker (.*);

`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: frequency ordered list
// Drives keys through the start/busy request port and checks every result
// strobe against a cycle-free model of the count-ordered table. Directed
// lookups, skewed random traffic with sender gaps, a drain pause, repeated
// hits on two hot entries and a final gap-free burst run in turn.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  import fol_pkg::*;

  localparam int NUM_SLOTS   = ENTRIES_DEF;
  localparam int CNT_BITS    = COUNT_BITS_DEF;
  localparam int STALL_LIMIT = 2000;  // cycles with no transaction at all
  localparam int TAIL_CYCLES = 8;     // settle time after the last result
  localparam int HOT_HITS    = 20;    // hits per hot entry in a row

  localparam logic [CNT_BITS-1:0] CNT_TOP = '1;

  // One result strobe as the block reports it.
  typedef struct packed {
    logic                      hit;
    logic [SLOT_BITS-1:0]      old_slot;
    logic [SLOT_BITS-1:0]      new_slot;
    logic [COUNT_OUT_BITS-1:0] new_count;
  } lookup_res_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic [KEY_BITS-1:0]       key = '0;
  logic                      busy;
  logic                      done;
  logic                      hit;
  logic [SLOT_BITS-1:0]      old_slot;
  logic [SLOT_BITS-1:0]      new_slot;
  logic [COUNT_OUT_BITS-1:0] new_count;

  // Shadow copy of the table, updated at the moment a request is taken.
  logic [KEY_BITS-1:0] shadow_keys   [NUM_SLOTS];
  logic [CNT_BITS-1:0] shadow_counts [NUM_SLOTS];

  lookup_res_t pending_results[$];
  int          mismatch_count = 0;
  int          stall_cycles = 0;

  frequency_ordered_list dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .key       (key),
    .done      (done),
    .hit       (hit),
    .old_slot  (old_slot),
    .new_slot  (new_slot),
    .new_count (new_count)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Table model
  // --------------------------------------------------------------------------

  // Load the after-reset order: slot i holds key i+1, every count zero.
  task automatic clear_shadow();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      shadow_keys[i]   = KEY_BITS'(i + 1);
      shadow_counts[i] = '0;
    end
  endtask

  // Look a key up in the shadow table, apply the frequency-count move and
  // return the result the block must report for it.
  function automatic lookup_res_t predict_lookup(logic [KEY_BITS-1:0] k);
    lookup_res_t         res;
    int                  found;
    int                  dest;
    logic [CNT_BITS-1:0] cnt;
    res   = '0;
    found = -1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (found < 0 && shadow_keys[i] == k) found = i;
    end
    // A miss leaves the table alone and reports zeros beside the hit flag.
    if (found < 0) return res;
    cnt = shadow_counts[found];
    if (cnt != CNT_TOP) cnt = cnt + 1'b1;
    // Walk forward past every earlier entry with a strictly smaller count.
    dest = found;
    while (dest > 0 && shadow_counts[dest-1] < cnt) dest--;
    // Shift the entries in between back by one slot.
    for (int i = found; i > dest; i--) begin
      shadow_keys[i]   = shadow_keys[i-1];
      shadow_counts[i] = shadow_counts[i-1];
    end
    shadow_keys[dest]   = k;
    shadow_counts[dest] = cnt;
    res.hit       = 1'b1;
    res.old_slot  = SLOT_BITS'(found);
    res.new_slot  = SLOT_BITS'(dest);
    res.new_count = COUNT_OUT_BITS'(cnt);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Present one key and hold it until the block takes the transaction. Leave
  // start high afterwards: the next call or a pause decides what follows, so
  // start sees only one assignment per time step.
  task automatic send_key(input logic [KEY_BITS-1:0] k);
    start <= 1'b1;
    key   <= k;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Taken at this edge: predict now so the table order matches the block.
    pending_results.push_back(predict_lookup(k));
  endtask

  // Drop start and idle the request port for a number of cycles.
  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop start and idle until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Pick a key: mostly hits, with a few hot keys so entries keep moving,
  // and some misses spread over the unused key space.
  function automatic logic [KEY_BITS-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 12) return KEY_BITS'($urandom_range(NUM_SLOTS + 1, (1 << KEY_BITS) - 1));
    if (r < 50) return KEY_BITS'($urandom_range(1, 4));
    return KEY_BITS'($urandom_range(1, NUM_SLOTS));
  endfunction

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Check every strobe against the oldest expectation; the block cannot be
  // held off, so a strobe is a transaction in itself.
  always @(posedge clk) begin
    lookup_res_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, hit", hit, 0);
      end else begin
        want = pending_results.pop_front();
        if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
        if (old_slot !== want.old_slot) report_mismatch("old_slot", old_slot, want.old_slot);
        if (new_slot !== want.new_slot) report_mismatch("new_slot", new_slot, want.new_slot);
        if (new_count !== want.new_count)
          report_mismatch("new_count", new_count, want.new_count);
      end
    end
  end

  // Watchdog: end the run when neither a request nor a result moves for too
  // long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Misses at the key extremes and alternating patterns, the last slot moving
  // all the way to the front, entries that stay put and short forward moves.
  task automatic test_directed_lookups();
    logic [KEY_BITS-1:0] keys[$];
    keys = '{6'd0, 6'd63, 6'd21, 6'd42, 6'd17, 6'd16, 6'd16, 6'd1, 6'd15, 6'd1,
             6'd1, 6'd15, 6'd15, 6'd14, 6'd8, 6'd8, 6'd8, 6'd32, 6'd31, 6'd2};
    foreach (keys[i]) send_key(keys[i]);
  endtask

  // Skewed random keys in stretches of 50 with different gap densities,
  // some stretches with no gaps at all.
  task automatic test_random_traffic(input int num_items);
    int idle_pct;
    for (int n = 0; n < num_items; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 25;
          default: idle_pct = 70;
        endcase
      end
      if ($urandom_range(0, 99) < idle_pct) pause_sender($urandom_range(1, 5));
      send_key(pick_key());
    end
  endtask

  // Hold the sender until the block has nothing in flight, then resume.
  task automatic test_drain_pause();
    repeat (10) send_key(pick_key());
    drain_results();
    repeat (10) send_key(pick_key());
  endtask

  // Hammer two entries in turn so each climbs past colder ones, then
  // alternate them so ties between their counts hold one behind the other.
  task automatic test_hot_entries();
    repeat (HOT_HITS) send_key(6'd5);
    repeat (HOT_HITS) send_key(6'd9);
    send_key(6'd9);
    send_key(6'd5);
    send_key(6'd9);
  endtask

  initial begin
    clear_shadow();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_lookups();
    test_random_traffic(1120);
    test_drain_pause();
    // No sender gaps from here on.
    test_hot_entries();
    repeat (100) send_key(pick_key());

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch("results left over", pending_results.size(), 0);
    end
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/fol_pkg.sv
rtl/core/fol_ctrl.sv
rtl/core/fol_datapath.sv
rtl/core/frequency_ordered_list.sv
rtl/core/fol_checker.sv
verif/testbench.sv
